### design/wheel_command_frame_parser_unit_assert.svh
// Assertion macros for the wheel command frame parser checks.
`ifndef WHEEL_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH
`define WHEEL_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WCFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WCFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wcfp_pkg.sv
// Shared constants, types and group decode function for the frame parser.
`default_nettype none

package wcfp_pkg;

    localparam int FRAME_LEN = 17;
    localparam int GROUPS    = 4;
    localparam int GROUP_LEN = 4;
    localparam int COUNT_W   = 5;
    localparam int FS_W      = 15;
    localparam int CMD_W     = 16;
    localparam int MAG_W     = 8;
    localparam int NUM_W     = 10;
    localparam int PROD_W    = MAG_W + FS_W;
    localparam int MODE_POS  = 16;

    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [NUM_W-1:0] MAG_LIMIT = 10'd255;

    localparam logic [FS_W-1:0] DUTY_FS_RESET    = 15'd32767;
    localparam logic [FS_W-1:0] CURRENT_FS_RESET = 15'd6000;

    // configuration register indexes
    localparam logic REG_DUTY_FS    = 1'b0;
    localparam logic REG_CURRENT_FS = 1'b1;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    typedef struct packed {
        frame_t             chars;
        logic [COUNT_W-1:0] count;
        logic               mode;
    } frame_view_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             clip;
        logic             positive;
    } group_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } wcfp_adv_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CHAR_ZERO:8'h39]};
    endfunction

    // Sign char at base, then up to three number chars read like toInt.
    function automatic group_t decode_group(input frame_t chars,
                                            input logic [COUNT_W-1:0] cnt,
                                            input logic [COUNT_W-1:0] base,
                                            input logic positive_in);
        logic             positive;
        logic             in_digits;
        logic             done;
        logic             num_neg;
        logic [NUM_W-1:0] val;
        logic [7:0]       ch;
        logic [COUNT_W-1:0] idx;
        group_t           g;
        positive  = positive_in;
        in_digits = 1'b0;
        done      = 1'b0;
        num_neg   = 1'b0;
        val       = '0;
        if (base < cnt)
        begin
            ch = chars[base];
            if (ch == CHAR_ZERO)
                positive = 1'b0;
            else if (ch == CHAR_ONE)
                positive = 1'b1;
        end
        for (int i = 1; i < GROUP_LEN; i++)
        begin
            idx = base + COUNT_W'(i);
            ch  = chars[idx];
            if (!done)
            begin
                if (idx >= cnt)
                    done = 1'b1;
                else if (is_digit(ch))
                begin
                    val = (val << 3) + (val << 1) + {6'b0, ch[3:0]};
                    in_digits = 1'b1;
                end
                else if (in_digits)
                    done = 1'b1;
                else if (ch == CHAR_PLUS || ch == CHAR_MINUS)
                begin
                    num_neg   = (ch == CHAR_MINUS);
                    in_digits = 1'b1;
                end
                else if (!is_blank(ch))
                    done = 1'b1;
            end
        end
        g.positive = positive;
        g.neg      = (val != '0) && (positive == num_neg);
        g.clip     = (val > MAG_LIMIT);
        g.mag      = g.clip ? MAG_LIMIT[MAG_W-1:0] : val[MAG_W-1:0];
        return g;
    endfunction

endpackage

`default_nettype wire

### design/wcfp_collector.sv
// Frame collection: start/stop control, character buffer and torque mode.
`default_nettype none

module wcfp_collector (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           rx_byte,
    output wcfp_pkg::frame_view_t     view
);
    import wcfp_pkg::*;

    logic               collecting_reg, collecting_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               mode_reg, mode_next;
    frame_t             chars_reg;
    logic               is_start, is_end, store;
    logic               frame_mode;

    assign is_start = accept && (rx_byte == CHAR_S);
    assign is_end   = accept && (rx_byte == CHAR_F);
    assign store    = accept && !is_start && !is_end && collecting_reg
                      && (count_reg < COUNT_W'(FRAME_LEN));

    // mode char only counts once the frame holds position 16
    always_comb
    begin
        frame_mode = mode_reg;
        if (count_reg > COUNT_W'(MODE_POS))
        begin
            if (chars_reg[MODE_POS] == CHAR_ZERO)
                frame_mode = 1'b0;
            else if (chars_reg[MODE_POS] == CHAR_ONE)
                frame_mode = 1'b1;
        end
    end

    always_comb
    begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        mode_next       = mode_reg;
        if (is_start)
        begin
            collecting_next = 1'b1;
            count_next      = '0;
        end
        else if (is_end)
        begin
            collecting_next = 1'b0;
            count_next      = '0;
            mode_next       = frame_mode;
        end
        else if (store)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            mode_reg       <= 1'b0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            mode_reg       <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            chars_reg[count_reg] <= rx_byte;
    end

    assign view.chars = chars_reg;
    assign view.count = count_reg;
    assign view.mode  = frame_mode;

endmodule

`default_nettype wire

### design/wcfp_scale_lane.sv
// One wheel lane: magnitude times full scale, divide by 255, apply sign.
`default_nettype none

module wcfp_scale_lane (
    input  wire logic                         clk,
    input  wire wcfp_pkg::wcfp_adv_t          adv,
    input  wire logic [wcfp_pkg::MAG_W-1:0]   mag,
    input  wire logic                         neg,
    input  wire logic [wcfp_pkg::FS_W-1:0]    fs,
    output logic signed [wcfp_pkg::CMD_W-1:0] cmd
);
    import wcfp_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              neg2_reg;
    logic [PROD_W-1:0] x3_reg;
    logic [CMD_W-1:0]  q1_reg, q1_next;
    logic              neg3_reg;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [PROD_W:0]   approx;
    logic [PROD_W:0]   q1_times;
    logic [PROD_W:0]   rem;
    logic [CMD_W-1:0]  quot;

    // x/255 ~ (x + x/256 + x/65536)/256, low by at most one
    assign approx  = {1'b0, prod_reg} + (PROD_W+1)'(prod_reg >> 8)
                     + (PROD_W+1)'(prod_reg >> 16);
    assign q1_next = approx[PROD_W:8];

    assign q1_times = {q1_reg[PROD_W-8:0], 8'b0} - (PROD_W+1)'(q1_reg);
    assign rem      = {1'b0, x3_reg} - q1_times;
    assign quot     = q1_reg + CMD_W'(rem >= (PROD_W+1)'(MAG_LIMIT));
    assign cmd_next = neg3_reg ? (CMD_W'(0) - quot) : quot;

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            prod_reg <= PROD_W'(mag) * PROD_W'(fs);
            neg2_reg <= neg;
        end
        if (adv.s3)
        begin
            x3_reg   <= prod_reg;
            q1_reg   <= q1_next;
            neg3_reg <= neg2_reg;
        end
        if (adv.s4)
            cmd_reg <= cmd_next;
    end

    assign cmd = cmd_reg;

endmodule

`default_nettype wire

### design/wheel_command_frame_parser_unit.sv
// Top level of the wheel command frame parser.
//
// Input channel: in_valid/in_ready with rx_byte, one ASCII char per item.
// 'S' starts a frame, chars are buffered (up to 17), 'F' closes it and
// produces one result item, even with no frame open; others produce nothing.
// Output channel: out_valid/out_ready with torque_mode, four signed wheel
// commands and clipped.
// Throughput: one byte per cycle while in_ready is high. 'F' decodes at
// accept into a register, then each lane runs product, reciprocal estimate
// and correction stages; out_valid follows the correction stage register.
// When the receiver stalls the result holds and the pipeline fills;
// in_ready drops only once all four stages hold results, and is high
// whenever out_ready is high.
// Configuration: cfg_we/cfg_index/cfg_data writes a full scale at once;
// the user writes only while idle (unchecked). Reset clears frame state,
// mode (duty), pipeline valids, loads full scale resets. No clearing pass.
`default_nettype none

module wheel_command_frame_parser_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   rx_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              torque_mode,
    output logic signed [wcfp_pkg::CMD_W-1:0] left_front_cmd,
    output logic signed [wcfp_pkg::CMD_W-1:0] left_back_cmd,
    output logic signed [wcfp_pkg::CMD_W-1:0] right_back_cmd,
    output logic signed [wcfp_pkg::CMD_W-1:0] right_front_cmd,
    output logic                              clipped,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [wcfp_pkg::FS_W-1:0]    cfg_data
);
    import wcfp_pkg::*;

    logic [FS_W-1:0]  duty_fs_reg, cur_fs_reg;
    frame_view_t      view;
    logic             accept;
    group_t           grp [GROUPS];
    logic             any_clip;
    logic             en1, en2, en3, en4;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             v1_next;
    logic [MAG_W-1:0] mag1_reg [GROUPS];
    logic             neg1_reg [GROUPS];
    logic [FS_W-1:0]  fs1_reg;
    logic             mode1_reg, mode2_reg, mode3_reg, mode4_reg;
    logic             clip1_reg, clip2_reg, clip3_reg, clip4_reg;
    wcfp_adv_t        adv;
    logic signed [CMD_W-1:0] lane_cmd [GROUPS];

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_fs_reg <= DUTY_FS_RESET;
            cur_fs_reg  <= CURRENT_FS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DUTY_FS:    duty_fs_reg <= cfg_data;
                REG_CURRENT_FS: cur_fs_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    wcfp_collector u_collector (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .view    (view)
    );

    // sign carries from group to group
    always_comb
    begin
        logic positive;
        positive = 1'b1;
        any_clip = 1'b0;
        for (int g = 0; g < GROUPS; g++)
        begin
            grp[g]   = decode_group(view.chars, view.count,
                                    COUNT_W'(g * GROUP_LEN), positive);
            positive = grp[g].positive;
            any_clip = any_clip | grp[g].clip;
        end
    end

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    assign adv.s2 = en2;
    assign adv.s3 = en3;
    assign adv.s4 = en4;

    assign v1_next = en1 ? (accept && (rx_byte == CHAR_F)) : v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                mag1_reg[g] <= grp[g].mag;
                neg1_reg[g] <= grp[g].neg;
            end
            fs1_reg   <= view.mode ? cur_fs_reg : duty_fs_reg;
            mode1_reg <= view.mode;
            clip1_reg <= any_clip;
        end
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            clip2_reg <= clip1_reg;
        end
        if (en3)
        begin
            mode3_reg <= mode2_reg;
            clip3_reg <= clip2_reg;
        end
        if (en4)
        begin
            mode4_reg <= mode3_reg;
            clip4_reg <= clip3_reg;
        end
    end

    for (genvar g = 0; g < GROUPS; g++)
    begin : g_lane
        wcfp_scale_lane u_lane (
            .clk (clk),
            .adv (adv),
            .mag (mag1_reg[g]),
            .neg (neg1_reg[g]),
            .fs  (fs1_reg),
            .cmd (lane_cmd[g])
        );
    end

    assign out_valid       = v4_reg;
    assign torque_mode     = mode4_reg;
    assign clipped         = clip4_reg;
    assign left_front_cmd  = lane_cmd[0];
    assign left_back_cmd   = lane_cmd[1];
    assign right_back_cmd  = lane_cmd[2];
    assign right_front_cmd = lane_cmd[3];

endmodule

`default_nettype wire

### design/wcfp_checker.sv
// Port-level checks for the frame parser and their bind to the top level.
`default_nettype none

`include "wheel_command_frame_parser_unit_assert.svh"

module wcfp_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_ready,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic                         torque_mode,
    input  wire logic signed [wcfp_pkg::CMD_W-1:0] left_front_cmd,
    input  wire logic signed [wcfp_pkg::CMD_W-1:0] left_back_cmd,
    input  wire logic signed [wcfp_pkg::CMD_W-1:0] right_back_cmd,
    input  wire logic signed [wcfp_pkg::CMD_W-1:0] right_front_cmd,
    input  wire logic                         clipped
);

    `WCFP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")

    `WCFP_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(torque_mode) && $stable(clipped) && $stable(left_front_cmd) && $stable(right_front_cmd), "result changed under stall")

    // a draining receiver never throttles the byte stream
    `WCFP_ASSERT_IMP(a_no_throttle, out_ready, in_ready, "input stalled while output drains")

    // commands are bounded by +-32767
    `WCFP_ASSERT_IMP(a_cmd_range, out_valid, left_front_cmd != 16'h8000 && left_back_cmd != 16'h8000 && right_back_cmd != 16'h8000 && right_front_cmd != 16'h8000, "command out of range")

endmodule

bind wheel_command_frame_parser_unit wcfp_checker u_wcfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .torque_mode     (torque_mode),
    .left_front_cmd  (left_front_cmd),
    .left_back_cmd   (left_back_cmd),
    .right_back_cmd  (right_back_cmd),
    .right_front_cmd (right_front_cmd),
    .clipped         (clipped)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the wheel command frame parser unit.
`timescale 1ns / 1ps

module tb_top;
    import wcfp_pkg::*;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic              mode;
        logic [CMD_W-1:0]  lf;
        logic [CMD_W-1:0]  lb;
        logic [CMD_W-1:0]  rb;
        logic [CMD_W-1:0]  rf;
        logic              clip;
    } wheel_result_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [7:0]               rx_byte = 8'h00;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     torque_mode;
    logic signed [CMD_W-1:0]  left_front_cmd;
    logic signed [CMD_W-1:0]  left_back_cmd;
    logic signed [CMD_W-1:0]  right_back_cmd;
    logic signed [CMD_W-1:0]  right_front_cmd;
    logic                     clipped;
    logic                     cfg_we = 1'b0;
    logic                     cfg_index = REG_DUTY_FS;
    logic [FS_W-1:0]          cfg_data = '0;

    wheel_command_frame_parser_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .torque_mode     (torque_mode),
        .left_front_cmd  (left_front_cmd),
        .left_back_cmd   (left_back_cmd),
        .right_back_cmd  (right_back_cmd),
        .right_front_cmd (right_front_cmd),
        .clipped         (clipped),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // frame state mirror
    logic            rx_collecting = 1'b0;
    int              rx_count = 0;
    logic [7:0]      rx_chars [FRAME_LEN];
    logic            rx_mode = 1'b0;
    logic [FS_W-1:0] duty_scale = DUTY_FS_RESET;
    logic [FS_W-1:0] current_scale = CURRENT_FS_RESET;

    wheel_result_t   expected_cmds [$];
    logic [7:0]      pending_bytes [$];
    int              queued_count = 0;
    int              sent_count;
    int              error_count = 0;
    int              idle_pct = 0;
    int              gap_left = 0;
    int              hold_left = 0;
    logic            long_hold_armed = 1'b0;
    logic            long_hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // number field after a sign char: blanks, one optional sign, then digits
    function automatic logic [9:0] read_magnitude(input int first, output logic minus);
        int         stop;
        int         p;
        logic [9:0] val;
        minus = 1'b0;
        val   = '0;
        p     = first;
        stop  = (first + 3 > rx_count) ? rx_count : first + 3;
        while (p < stop && (rx_chars[p] == CHAR_SPACE ||
               (rx_chars[p] >= CHAR_TAB && rx_chars[p] <= CHAR_CR)))
            p++;
        if (p < stop && (rx_chars[p] == CHAR_PLUS || rx_chars[p] == CHAR_MINUS))
        begin
            minus = (rx_chars[p] == CHAR_MINUS);
            p++;
        end
        while (p < stop && rx_chars[p] >= CHAR_ZERO && rx_chars[p] <= CHAR_NINE)
        begin
            val = 10'(val * 10) + 10'(rx_chars[p] - CHAR_ZERO);
            p++;
        end
        return val;
    endfunction

    function automatic wheel_result_t close_frame();
        wheel_result_t   r;
        logic            positive;
        logic            clip;
        logic            minus;
        logic            neg;
        logic [FS_W-1:0] fs;
        logic [9:0]      mag;
        logic [31:0]     cmd;
        logic [CMD_W-1:0] lane [GROUPS];
        positive = 1'b1;
        clip     = 1'b0;
        if (rx_count > MODE_POS)
        begin
            if (rx_chars[MODE_POS] == CHAR_ZERO)
                rx_mode = 1'b0;
            else if (rx_chars[MODE_POS] == CHAR_ONE)
                rx_mode = 1'b1;
        end
        fs = rx_mode ? current_scale : duty_scale;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (GROUP_LEN * g < rx_count)
            begin
                if (rx_chars[GROUP_LEN * g] == CHAR_ZERO)
                    positive = 1'b0;
                else if (rx_chars[GROUP_LEN * g] == CHAR_ONE)
                    positive = 1'b1;
            end
            mag = read_magnitude(GROUP_LEN * g + 1, minus);
            neg = (positive != !minus) && (mag != 0);
            if (mag > MAG_LIMIT)
            begin
                mag  = MAG_LIMIT;
                clip = 1'b1;
            end
            cmd = (32'(mag) * 32'(fs)) / 32'(MAG_LIMIT);
            if (neg)
                cmd = -cmd;
            lane[g] = cmd[CMD_W-1:0];
        end
        r = {rx_mode, lane[0], lane[1], lane[2], lane[3], clip};
        return r;
    endfunction

    function automatic void take_rx_byte(input logic [7:0] c);
        if (c == CHAR_S)
        begin
            rx_count      = 0;
            rx_collecting = 1'b1;
        end
        else if (c == CHAR_F)
        begin
            expected_cmds.push_back(close_frame());
            rx_count      = 0;
            rx_collecting = 1'b0;
        end
        else if (rx_collecting && rx_count < FRAME_LEN)
        begin
            rx_chars[rx_count] = c;
            rx_count++;
        end
    endfunction

    function automatic void report_mismatch(input string what, input wheel_result_t want,
                                            input wheel_result_t seen);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected mode=%0d cmd=%0d,%0d,%0d,%0d clip=%0d, got mode=%0d cmd=%0d,%0d,%0d,%0d clip=%0d",
                     what, want.mode, $signed(want.lf), $signed(want.lb), $signed(want.rb),
                     $signed(want.rf), want.clip, seen.mode, $signed(seen.lf),
                     $signed(seen.lb), $signed(seen.rb), $signed(seen.rf), seen.clip);
    endfunction

    // driver: offers queued bytes, random gaps only while the slot is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            rx_byte    <= 8'h00;
            sent_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                take_rx_byte(rx_byte);
                sent_count <= sent_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0 && idle_pct != 0 &&
                         $urandom_range(0, 99) < idle_pct)
                begin
                    gap_left = $urandom_range(0, 16);
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    rx_byte  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted item, drives out_ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        wheel_result_t seen;
        wheel_result_t want;
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {torque_mode, left_front_cmd, left_back_cmd, right_back_cmd,
                        right_front_cmd, clipped};
                if (expected_cmds.size() == 0)
                    report_mismatch("unexpected result", '0, seen);
                else
                begin
                    want = expected_cmds.pop_front();
                    if (seen !== want)
                        report_mismatch("result mismatch", want, seen);
                end
            end
            if (long_hold_armed && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                hold_left = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic void push_item(input logic [7:0] b);
        pending_bytes.push_back(b);
        queued_count++;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_S || b == CHAR_F);
        return b;
    endfunction

    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 3))
            0: return ($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                                  : CHAR_TAB + 8'($urandom_range(0, 4));
            1: return CHAR_PLUS;
            2: return CHAR_MINUS;
            default: return plain_byte();
        endcase
    endfunction

    function automatic logic [7:0] frame_char(input int pos);
        int r;
        r = $urandom_range(0, 99);
        if (pos >= FRAME_LEN)
            return plain_byte();
        if (pos == MODE_POS || pos % GROUP_LEN == 0)
            return (r < 45) ? CHAR_ZERO : (r < 90) ? CHAR_ONE : plain_byte();
        // keep leading digit low most of the time so saturation stays a minority
        if (pos % GROUP_LEN == 1)
        begin
            if (r < 70)
                return CHAR_ZERO + 8'($urandom_range(0, 2));
            if (r < 85)
                return CHAR_ZERO + 8'($urandom_range(3, 9));
            return odd_char();
        end
        return (r < 85) ? CHAR_ZERO + 8'($urandom_range(0, 9)) : odd_char();
    endfunction

    // mostly complete frames; some short, overlong, restarted, unopened or unclosed
    function automatic int push_frame();
        int kind;
        int n;
        int m;
        int pushed;
        kind   = $urandom_range(0, 19);
        n      = FRAME_LEN;
        pushed = 0;
        if (kind <= 1)
            n = $urandom_range(0, FRAME_LEN - 1);
        else if (kind == 2)
            n = FRAME_LEN + $urandom_range(1, 6);
        if (kind != 3)
        begin
            push_item(CHAR_S);
            pushed++;
        end
        if (kind == 4)
        begin
            m = $urandom_range(1, 10);
            for (int i = 0; i < m; i++)
                push_item(frame_char(i));
            push_item(CHAR_S);
            pushed += m + 1;
        end
        for (int i = 0; i < n; i++)
            push_item(frame_char(i));
        pushed += n;
        if (kind != 5)
        begin
            push_item(CHAR_F);
            pushed++;
        end
        return pushed;
    endfunction

    task automatic push_random_phase(input int target);
        int frame_bytes;
        int m;
        frame_bytes = 0;
        while (frame_bytes < target)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                m = $urandom_range(1, 4);
                for (int i = 0; i < m; i++)
                    push_item(8'($urandom_range(0, 255)));
            end
            else
                frame_bytes += push_frame();
        end
    endtask

    task automatic write_full_scale(input logic idx, input logic [FS_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_DUTY_FS)
            duty_scale = value;
        else
            current_scale = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // all bytes taken, all results seen, then let the pipeline settle
    task automatic wait_drained();
        while (sent_count != queued_count || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        string directed_text;
        directed_text = "S02551+992 -509991FS7SF";
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_full_scale(REG_DUTY_FS, DUTY_FS_RESET);
        write_full_scale(REG_CURRENT_FS, CURRENT_FS_RESET);
        idle_pct = 10;
        // close with no frame open, ignored bytes, then a frame with odd groups
        push_item(CHAR_F);
        push_item(8'hFF);
        push_item(8'h00);
        for (int i = 0; i < directed_text.len(); i++)
            push_item(directed_text[i]);
        wait_drained();

        write_full_scale(REG_DUTY_FS, 15'd0);
        write_full_scale(REG_CURRENT_FS, 15'h7FFF);
        idle_pct = 15;
        push_random_phase(250);
        wait_drained();

        write_full_scale(REG_DUTY_FS, 15'd1);
        write_full_scale(REG_CURRENT_FS, 15'd0);
        idle_pct = 4;
        push_random_phase(250);
        wait_drained();

        write_full_scale(REG_DUTY_FS, 15'($urandom_range(0, 32767)));
        write_full_scale(REG_CURRENT_FS, 15'($urandom_range(0, 32767)));
        idle_pct = 10;
        push_random_phase(300);
        @(posedge clk);
        long_hold_armed <= 1'b1;
        wait_drained();

        write_full_scale(REG_DUTY_FS, 15'h7FFF);
        write_full_scale(REG_CURRENT_FS, 15'd1);
        idle_pct = 20;
        push_random_phase(250);
        wait_drained();

        write_full_scale(REG_DUTY_FS, 15'($urandom_range(0, 32767)));
        write_full_scale(REG_CURRENT_FS, 15'($urandom_range(0, 32767)));
        idle_pct = 0;
        push_random_phase(200);
        wait_drained();
        repeat (10) @(posedge clk);

        if (expected_cmds.size() != 0)
        begin
            $display("%0d results never arrived", expected_cmds.size());
            error_count += expected_cmds.size();
        end
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/wcfp_pkg.sv
design/wcfp_collector.sv
design/wcfp_scale_lane.sv
design/wheel_command_frame_parser_unit.sv
design/wcfp_checker.sv
tb/tb_top.sv
